// ===== hw/rtl/rrlp_pkg.sv =====
package rrlp_pkg;

    localparam int LINE_MAX_DEF = 128;
    localparam int TEXT_MAX_DEF = 64;
    localparam int PREFIX_LEN   = 5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    // Field numbers of a +RCV= line.
    localparam logic [2:0] FLD_ADDR    = 3'd0;
    localparam logic [2:0] FLD_LEN     = 3'd1;
    localparam logic [2:0] FLD_PAYLOAD = 3'd2;
    localparam logic [2:0] FLD_SNR     = 3'd3;
    localparam logic [2:0] FLD_RSSI    = 3'd4;
    localparam logic [2:0] FLD_DONE    = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CHECK     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OUT_OVERFLOW = 2'd0,
        OUT_SUMMARY  = 2'd1,
        OUT_TEXT     = 2'd2
    } out_sel_t;

    typedef enum logic [1:0] {
        P_BLANK  = 2'd0,
        P_DIGITS = 2'd1,
        P_DONE   = 2'd2
    } num_phase_t;

    // Decimal number scanner state: magnitude saturates at 65536, and the
    // low byte is kept modulo 256 alongside it.
    typedef struct packed {
        num_phase_t  phase;
        logic        neg;
        logic [16:0] mag;
        logic [7:0]  modv;
    } num_t;

    localparam num_t NUM_INIT = '{phase: P_BLANK, neg: 1'b0, mag: 17'd0, modv: 8'd0};

    typedef struct packed {
        logic     store;
        logic     line_clear;
        logic     scan_start;
        logic     scan_step;
        logic     emit_start;
        logic     emit_read;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic is_term;
        logic overflow;
        logic prefix_ok;
        logic scan_end;
        logic emit_text;
        logic emit_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] addr;
        logic [15:0] id;
        logic [7:0]  snr;
        logic [8:0]  rssi;
        logic        is_ack;
        logic [15:0] acked;
        logic [7:0]  text;
        logic        byte_valid;
        logic        last;
    } res_t;

    function automatic logic [7:0] rcv_char(logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h2B;
            3'd1:    r = 8'h52;
            3'd2:    r = 8'h43;
            3'd3:    r = 8'h56;
            default: r = 8'h3D;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ack_char(logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h41;
            2'd1:    r = 8'h43;
            2'd2:    r = 8'h4B;
            default: r = 8'h3A;
        endcase
        return r;
    endfunction

    function automatic num_t num_step(num_t s, logic [7:0] c);
        num_t        r;
        logic [3:0]  d;
        logic        digit;
        logic        blank;
        logic [19:0] prod;
        logic [7:0]  prodm;
        r     = s;
        d     = c[3:0];
        digit = (c >= 8'h30) && (c <= 8'h39);
        blank = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
        prod  = {s.mag, 3'b000} + {2'b00, s.mag, 1'b0} + {16'd0, d};
        prodm = {s.modv[4:0], 3'b000} + {s.modv[6:0], 1'b0} + {4'd0, d};
        case (s.phase)
            P_BLANK:
            begin
                if (blank)
                begin
                    r.phase = P_BLANK;
                end
                else if ((c == CHAR_PLUS) || (c == CHAR_MINUS))
                begin
                    r.neg   = (c == CHAR_MINUS);
                    r.phase = P_DIGITS;
                end
                else if (digit)
                begin
                    r.mag   = (prod > 20'd65536) ? 17'd65536 : prod[16:0];
                    r.modv  = prodm;
                    r.phase = P_DIGITS;
                end
                else
                begin
                    r.phase = P_DONE;
                end
            end
            P_DIGITS:
            begin
                if (digit)
                begin
                    r.mag  = (prod > 20'd65536) ? 17'd65536 : prod[16:0];
                    r.modv = prodm;
                end
                else
                begin
                    r.phase = P_DONE;
                end
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] clamp_u16(num_t s);
        logic [15:0] r;
        if (s.neg)
            r = 16'd0;
        else if (s.mag[16])
            r = 16'hFFFF;
        else
            r = s.mag[15:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp_u8(num_t s);
        logic [7:0] r;
        if (s.neg)
            r = 8'd0;
        else if (s.mag > 17'd255)
            r = 8'hFF;
        else
            r = s.mag[7:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp_snr(num_t s);
        logic [7:0] r;
        if (s.neg)
            r = (s.mag > 17'd128) ? 8'h80 : 8'(17'd0 - s.mag);
        else
            r = (s.mag > 17'd127) ? 8'h7F : s.mag[7:0];
        return r;
    endfunction

    function automatic logic [8:0] clamp_rssi(num_t s);
        logic [8:0] r;
        if (s.neg)
            r = (s.mag > 17'd256) ? 9'h100 : 9'(17'd0 - s.mag);
        else
            r = (s.mag > 17'd255) ? 9'h0FF : s.mag[8:0];
        return r;
    endfunction

    function automatic logic [7:0] num_mod(num_t s);
        return s.neg ? (8'd0 - s.modv) : s.modv;
    endfunction

endpackage

// ===== hw/rtl/radio_receive_line_parser.sv =====
// Channel | Direction | Beat contents
// s_*     | in        | tdata[7:0] rx_byte
// m_*     | out       | tdata: address, id, snr, rssi, ack flag, acked id, text byte;
//         |           | tuser: status, byte_valid; tlast: last beat of the run
//
// An ordinary received byte is taken and written to the line store.
// A CR or LF on a +RCV= line starts a scan of the stored line through the single
// store read port, with a read state and a process state for each byte from the
// sixth on and for the closing position, then sends either one summary beat or
// one result beat per text byte, each byte read back from the same port.
// Reset clears the line fill count, the sticky address, snr and rssi and the
// output valid flag; the line store itself needs no clearing pass.
// A stall on m_tready holds the output register and the states that load it;
// ordinary bytes flow in while a result waits, but not during a scan, run or overflow.
module radio_receive_line_parser #(
    parameter int LINE_MAX = rrlp_pkg::LINE_MAX_DEF,
    parameter int TEXT_MAX = rrlp_pkg::TEXT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] sender_address, [31:16] message_id, [39:32] link_snr,
    // [48:40] link_rssi, [49] is_ack, [65:50] acked_id, [73:66] text_byte
    output logic [79:0] m_tdata,
    output logic [7:0]  m_tuser,   // [1:0] status, [2] byte_valid
    output logic        m_tlast
);
    import rrlp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences storing, the end-of-line scan and the result
    // run; the datapath holds the line store, the number scanners and the
    // output register.
    rrlp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrlp_dpath #(
        .LINE_MAX (LINE_MAX),
        .TEXT_MAX (TEXT_MAX)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/rrlp_ctrl.sv =====
module rrlp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rrlp_pkg::stat_t stat,
    output rrlp_pkg::cmd_t  cmd
);
    import rrlp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_OVF       = 8'b0000_0010,
        S_SCAN_RD   = 8'b0000_0100,
        S_SCAN_PROC = 8'b0000_1000,
        S_DECIDE    = 8'b0001_0000,
        S_SUMMARY   = 8'b0010_0000,
        S_TEXT_RD   = 8'b0100_0000,
        S_TEXT_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = OUT_TEXT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (stat.is_term)
                    begin
                        if (stat.prefix_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN_RD;
                        end
                        else
                        begin
                            cmd.line_clear = 1'b1;
                        end
                    end
                    else if (stat.overflow)
                    begin
                        cmd.line_clear = 1'b1;
                        state_next     = S_OVF;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_OVF:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_OVERFLOW;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_PROC;
            end
            S_SCAN_PROC:
            begin
                cmd.scan_step = 1'b1;
                state_next    = stat.scan_end ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                if (stat.emit_text)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_TEXT_RD;
                end
                else
                begin
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_SUMMARY;
                    cmd.line_clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TEXT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = S_TEXT_OUT;
            end
            S_TEXT_OUT:
            begin
                cmd.emit_read = 1'b1;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.line_clear = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_TEXT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/rrlp_dpath.sv =====
module rrlp_dpath #(
    parameter int LINE_MAX = rrlp_pkg::LINE_MAX_DEF,
    parameter int TEXT_MAX = rrlp_pkg::TEXT_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      in_data,
    input  rrlp_pkg::cmd_t  cmd,
    output rrlp_pkg::stat_t stat,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [79:0]     m_tdata,
    output logic [7:0]      m_tuser,
    output logic            m_tlast
);
    import rrlp_pkg::*;

    localparam int AW = $clog2(LINE_MAX);
    localparam int PW = $clog2(LINE_MAX + 1);
    localparam int KW = $clog2(TEXT_MAX + 1);

    logic [7:0] mem [LINE_MAX];
    logic [7:0] rdata_reg;
    logic [PW-1:0] rd_addr;

    logic [PW-1:0] count_reg, count_next;
    logic [2:0]    prefix_reg, prefix_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    fidx_reg, fidx_next;
    logic [PW-1:0] ms_reg, ms_next;
    logic [7:0]    len_reg, len_next;
    num_t          num_reg, num_next;
    num_t          ack_num_reg, ack_num_next;
    logic          ack_ok_reg, ack_ok_next;
    logic [7:0]    sum_reg, sum_next;
    logic          lp_valid_reg, lp_valid_next;
    logic [PW-1:0] lp_reg, lp_next;
    logic          q_valid_reg, q_valid_next;
    logic [PW-1:0] q_reg, q_next;
    logic [7:0]    sum_lp_reg, sum_lp_next;
    logic [15:0]   seg_lp_reg, seg_lp_next;
    status_t       res_status_reg, res_status_next;
    logic [15:0]   id_reg, id_next;
    logic          is_ack_reg, is_ack_next;
    logic [15:0]   acked_reg, acked_next;
    logic [PW-1:0] tl_reg, tl_next;
    logic [15:0]   addr_reg, addr_next;
    logic [7:0]    snr_reg, snr_next;
    logic [8:0]    rssi_reg, rssi_next;
    logic [KW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    logic [7:0]    ch;
    logic          is_comma;
    logic [PW-1:0] offset;
    logic          pay_end;
    logic [7:0]    sum_comma;
    logic          check_ok;
    logic          text_too_long;
    logic          ack_hit;

    // Positions at or past the fill count read as a comma, which closes
    // the final field.
    assign ch            = (pos_reg < count_reg) ? rdata_reg : CHAR_COMMA;
    assign is_comma      = (ch == CHAR_COMMA);
    assign offset        = pos_reg - ms_reg;
    assign pay_end       = is_comma && (16'(offset) >= 16'(len_reg));
    assign sum_comma     = CHAR_COMMA + sum_lp_reg;
    assign check_ok      = ((CHECK_BASE - sum_comma) == num_mod(num_reg));
    assign text_too_long = 16'(tl_reg) > 16'(TEXT_MAX);
    assign ack_hit       = (16'(q_reg - ms_reg) >= 16'd4) && ack_ok_reg;

    assign rd_addr = cmd.emit_read ? (ms_reg + PW'(k_reg)) : pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[count_reg[AW-1:0]] <= in_data;
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    always_comb
    begin
        count_next      = count_reg;
        prefix_next     = prefix_reg;
        pos_next        = pos_reg;
        fidx_next       = fidx_reg;
        ms_next         = ms_reg;
        len_next        = len_reg;
        num_next        = num_reg;
        ack_num_next    = ack_num_reg;
        ack_ok_next     = ack_ok_reg;
        sum_next        = sum_reg;
        lp_valid_next   = lp_valid_reg;
        lp_next         = lp_reg;
        q_valid_next    = q_valid_reg;
        q_next          = q_reg;
        sum_lp_next     = sum_lp_reg;
        seg_lp_next     = seg_lp_reg;
        res_status_next = res_status_reg;
        id_next         = id_reg;
        is_ack_next     = is_ack_reg;
        acked_next      = acked_reg;
        tl_next         = tl_reg;
        addr_next       = addr_reg;
        snr_next        = snr_reg;
        rssi_next       = rssi_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (cmd.store)
        begin
            count_next = count_reg + 1'b1;
            if ((count_reg < PW'(PREFIX_LEN)) && (PW'(prefix_reg) == count_reg) &&
                (in_data == rcv_char(prefix_reg)))
                prefix_next = prefix_reg + 1'b1;
        end

        if (cmd.line_clear)
        begin
            count_next  = '0;
            prefix_next = '0;
        end

        if (cmd.scan_start)
        begin
            pos_next        = PW'(PREFIX_LEN);
            fidx_next       = FLD_ADDR;
            num_next        = NUM_INIT;
            res_status_next = ST_MALFORMED;
            id_next         = '0;
            is_ack_next     = 1'b0;
            acked_next      = '0;
            tl_next         = '0;
        end

        if (cmd.scan_step)
        begin
            pos_next = pos_reg + 1'b1;
            case (fidx_reg)
                FLD_ADDR:
                begin
                    if (is_comma)
                    begin
                        addr_next = clamp_u16(num_reg);
                        fidx_next = FLD_LEN;
                        num_next  = NUM_INIT;
                    end
                    else
                        num_next = num_step(num_reg, ch);
                end
                FLD_LEN:
                begin
                    if (is_comma)
                    begin
                        len_next      = clamp_u8(num_reg);
                        fidx_next     = FLD_PAYLOAD;
                        ms_next       = pos_reg + 1'b1;
                        num_next      = NUM_INIT;
                        sum_next      = '0;
                        lp_valid_next = 1'b0;
                        q_valid_next  = 1'b0;
                        ack_ok_next   = 1'b1;
                        ack_num_next  = NUM_INIT;
                    end
                    else
                        num_next = num_step(num_reg, ch);
                end
                FLD_PAYLOAD:
                begin
                    if (pay_end)
                    begin
                        // The last comma before the end splits off the check,
                        // the one before it splits the text from the id.
                        fidx_next = FLD_SNR;
                        num_next  = NUM_INIT;
                        if (lp_valid_reg)
                        begin
                            if (!check_ok)
                                res_status_next = ST_CHECK;
                            else if (q_valid_reg)
                            begin
                                res_status_next = ST_OK;
                                id_next         = seg_lp_reg;
                                tl_next         = q_reg - ms_reg;
                                is_ack_next     = ack_hit;
                                acked_next      = ack_hit ? clamp_u16(ack_num_reg) : 16'd0;
                            end
                        end
                    end
                    else
                    begin
                        sum_next = sum_reg + ch;
                        if (16'(offset) < 16'd4)
                        begin
                            if (ch != ack_char(offset[1:0]))
                                ack_ok_next = 1'b0;
                        end
                        else
                            ack_num_next = num_step(ack_num_reg, ch);
                        if (is_comma)
                        begin
                            q_next        = lp_reg;
                            q_valid_next  = lp_valid_reg;
                            lp_next       = pos_reg;
                            lp_valid_next = 1'b1;
                            sum_lp_next   = sum_reg;
                            seg_lp_next   = clamp_u16(num_reg);
                            num_next      = NUM_INIT;
                        end
                        else
                            num_next = num_step(num_reg, ch);
                    end
                end
                FLD_SNR:
                begin
                    if (is_comma)
                    begin
                        snr_next  = clamp_snr(num_reg);
                        fidx_next = FLD_RSSI;
                        num_next  = NUM_INIT;
                    end
                    else
                        num_next = num_step(num_reg, ch);
                end
                FLD_RSSI:
                begin
                    if (is_comma)
                    begin
                        rssi_next = clamp_rssi(num_reg);
                        fidx_next = FLD_DONE;
                    end
                    else
                        num_next = num_step(num_reg, ch);
                end
                default:
                begin
                    fidx_next = fidx_reg;
                end
            endcase
        end

        if (cmd.emit_start)
            k_next = '0;

        if (cmd.out_load)
        begin
            out_valid_next      = 1'b1;
            out_next.addr       = addr_reg;
            out_next.snr        = snr_reg;
            out_next.rssi       = rssi_reg;
            out_next.status     = ST_OK;
            out_next.id         = id_reg;
            out_next.is_ack     = is_ack_reg;
            out_next.acked      = acked_reg;
            out_next.text       = 8'd0;
            out_next.byte_valid = 1'b0;
            out_next.last       = 1'b1;
            case (cmd.out_sel)
                OUT_OVERFLOW:
                begin
                    out_next.status = ST_OVERFLOW;
                    out_next.id     = '0;
                    out_next.is_ack = 1'b0;
                    out_next.acked  = '0;
                end
                OUT_SUMMARY:
                begin
                    if (res_status_reg != ST_OK)
                    begin
                        out_next.status = res_status_reg;
                        out_next.id     = '0;
                        out_next.is_ack = 1'b0;
                        out_next.acked  = '0;
                    end
                    else if (text_too_long)
                        out_next.status = ST_OVERFLOW;
                end
                default:
                begin
                    out_next.text       = rdata_reg;
                    out_next.byte_valid = 1'b1;
                    out_next.last       = stat.emit_last;
                    k_next              = k_reg + 1'b1;
                end
            endcase
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prefix_reg    <= '0;
            addr_reg      <= '0;
            snr_reg       <= '0;
            rssi_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            addr_reg      <= addr_next;
            snr_reg       <= snr_next;
            rssi_reg      <= rssi_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        fidx_reg       <= fidx_next;
        ms_reg         <= ms_next;
        len_reg        <= len_next;
        num_reg        <= num_next;
        ack_num_reg    <= ack_num_next;
        ack_ok_reg     <= ack_ok_next;
        sum_reg        <= sum_next;
        lp_valid_reg   <= lp_valid_next;
        lp_reg         <= lp_next;
        q_valid_reg    <= q_valid_next;
        q_reg          <= q_next;
        sum_lp_reg     <= sum_lp_next;
        seg_lp_reg     <= seg_lp_next;
        res_status_reg <= res_status_next;
        id_reg         <= id_next;
        is_ack_reg     <= is_ack_next;
        acked_reg      <= acked_next;
        tl_reg         <= tl_next;
        out_reg        <= out_next;
    end

    always_comb
    begin
        stat.is_term   = (in_data == CHAR_CR) || (in_data == CHAR_LF);
        stat.overflow  = (count_reg >= PW'(LINE_MAX));
        stat.prefix_ok = (prefix_reg == 3'(PREFIX_LEN));
        stat.scan_end  = (pos_reg == count_reg);
        stat.emit_text = (res_status_reg == ST_OK) && (tl_reg != '0) && !text_too_long;
        stat.emit_last = ((16'(k_reg) + 16'd1) == 16'(tl_reg));
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.text, out_reg.acked, out_reg.is_ack, out_reg.rssi,
                       out_reg.snr, out_reg.id, out_reg.addr};
    assign m_tuser  = {5'd0, out_reg.byte_valid, out_reg.status};
    assign m_tlast  = out_reg.last;

    a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("line store count did not advance on a store");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten while a beat waits");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (pos_reg <= count_reg))
        else $error("line scan ran past the stored bytes");

    a_text_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && (cmd.out_sel == OUT_TEXT)) |->
        ((res_status_reg == ST_OK) && (16'(k_reg) < 16'(tl_reg))))
        else $error("text beat sent outside a checked text run");

endmodule
